>>> design/spc_pkg.sv
// Shared types, widths and helpers for the sphere/plane collision pipeline.
// Used by spc_front, spc_fifo, spc_back and sphere_plane_collision_response.
package spc_pkg;

  localparam int FRAC   = 16;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  localparam int QW     = 31;                    // impact time quotient bits
  localparam int SEPW   = 38;
  localparam int VNW    = 36;
  localparam int MW     = 57;
  localparam int KPW    = 56;
  localparam int KW     = KPW - FRAC;
  localparam int NKW    = 58;
  localparam int VFW    = 51;
  localparam int DVW    = 37;
  localparam int REMW   = SEPW - 1 + FRAC;
  localparam int TW     = DVW + QW - 1;
  localparam int OVW    = DVW + QW - FRAC;
  localparam int VTW    = 64;

  localparam logic [2:0] CFG_PLANE_X  = 3'd0;
  localparam logic [2:0] CFG_PLANE_Y  = 3'd1;
  localparam logic [2:0] CFG_PLANE_Z  = 3'd2;
  localparam logic [2:0] CFG_NORMAL_X = 3'd3;
  localparam logic [2:0] CFG_NORMAL_Y = 3'd4;
  localparam logic [2:0] CFG_NORMAL_Z = 3'd5;
  localparam logic [2:0] CFG_FRICTION = 3'd6;
  localparam logic [2:0] CFG_BOUNCE   = 3'd7;

  typedef struct packed {
    logic [2:0][31:0] plane;
    logic [2:0][17:0] nrm;
    logic [17:0]      fric;
    logic [17:0]      bnc;
  } cfg_t;

  typedef struct packed {
    logic [2:0][31:0]     p;
    logic [2:0][31:0]     v;
    logic [30:0]          dt;
    logic [SEPW-1:0]      sep;
    logic [VNW-1:0]       vn;
    logic [KPW-1:0]       kp;
    logic [2:0][MW-1:0]   m;
    logic [2:0][VFW-1:0]  vf;
    logic                 touch;
    logic                 appr;
  } item_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (x < -64'sd2147483648) r = 32'h8000_0000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

>>> design/sphere_plane_collision_response.sv
// Sphere/plane collision response, signed Q16.16. Accepts one ball per cycle
// while in_full is low and returns one result per ball, in order. Each ball
// passes three front, one queue and one setup stage, the 31-stage restoring
// divider (one impact-time bit per stage), then one multiply and one output
// stage. The plane registers are written on the cfg port, which is always
// ready; write them only while the block is idle.
// Depends on spc_pkg, spc_front, spc_fifo and spc_back.
module sphere_plane_collision_response (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [31:0] in_ball_pos_x,
  input  logic signed [31:0] in_ball_pos_y,
  input  logic signed [31:0] in_ball_pos_z,
  input  logic signed [31:0] in_ball_vel_x,
  input  logic signed [31:0] in_ball_vel_y,
  input  logic signed [31:0] in_ball_vel_z,
  input  logic [30:0]        in_ball_radius,
  input  logic [30:0]        in_time_step,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic               out_swept_hit,
  output logic [30:0]        out_time_left,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import spc_pkg::*;

  cfg_t  cfg_r;
  logic  q_push, q_full, q_pop, q_empty;
  item_t q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.plane <= '0;
      cfg_r.nrm   <= {18'd0, 18'd65536, 18'd0};
      cfg_r.fric  <= 18'd65536;
      cfg_r.bnc   <= 18'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PLANE_X:  cfg_r.plane[0] <= cfg_data;
        CFG_PLANE_Y:  cfg_r.plane[1] <= cfg_data;
        CFG_PLANE_Z:  cfg_r.plane[2] <= cfg_data;
        CFG_NORMAL_X: cfg_r.nrm[0]   <= cfg_data[17:0];
        CFG_NORMAL_Y: cfg_r.nrm[1]   <= cfg_data[17:0];
        CFG_NORMAL_Z: cfg_r.nrm[2]   <= cfg_data[17:0];
        CFG_FRICTION: cfg_r.fric     <= cfg_data[17:0];
        CFG_BOUNCE:   cfg_r.bnc      <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  spc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_ball_pos_x  (in_ball_pos_x),
    .in_ball_pos_y  (in_ball_pos_y),
    .in_ball_pos_z  (in_ball_pos_z),
    .in_ball_vel_x  (in_ball_vel_x),
    .in_ball_vel_y  (in_ball_vel_y),
    .in_ball_vel_z  (in_ball_vel_z),
    .in_ball_radius (in_ball_radius),
    .in_time_step   (in_time_step),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_wdata)
  );

  spc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  spc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_empty       (q_empty),
    .q_item        (q_rdata),
    .q_pop         (q_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_new_pos_x (out_new_pos_x),
    .out_new_pos_y (out_new_pos_y),
    .out_new_pos_z (out_new_pos_z),
    .out_new_vel_x (out_new_vel_x),
    .out_new_vel_y (out_new_vel_y),
    .out_new_vel_z (out_new_vel_z),
    .out_swept_hit (out_swept_hit),
    .out_time_left (out_time_left)
  );

endmodule

>>> design/spc_front.sv
// Front pipeline: accepts balls, forms separation and normal speed, classifies
// and prepares the products the back needs. Depends on spc_pkg.
module spc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic signed [31:0]  in_ball_pos_x,
  input  logic signed [31:0]  in_ball_pos_y,
  input  logic signed [31:0]  in_ball_pos_z,
  input  logic signed [31:0]  in_ball_vel_x,
  input  logic signed [31:0]  in_ball_vel_y,
  input  logic signed [31:0]  in_ball_vel_z,
  input  logic [30:0]         in_ball_radius,
  input  logic [30:0]         in_time_step,
  input  spc_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output spc_pkg::item_t      q_item
);
  import spc_pkg::*;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0][32:0] d;
    logic [30:0]      r;
    logic [30:0]      dt;
  } s1_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0][50:0] pd;
    logic [2:0][49:0] pv;
    logic [30:0]      r;
    logic [30:0]      dt;
  } s2_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [SEPW-1:0]  sep;
    logic [VNW-1:0]   vn;
    logic [30:0]      dt;
  } s3_t;

  logic fe;
  logic s1_v_r, s2_v_r, s3_v_r;
  s1_t  s1_r, s1_nxt;
  s2_t  s2_r, s2_nxt;
  s3_t  s3_r, s3_nxt;
  logic signed [52:0] sd;
  logic signed [51:0] sv;
  logic signed [38:0] negsep;
  logic [18:0]        fb;

  assign fe      = !(s3_v_r && q_full);
  assign in_full = !fe;
  assign q_push  = s3_v_r && fe;

  always_comb begin
    s1_nxt.p[0] = in_ball_pos_x;
    s1_nxt.p[1] = in_ball_pos_y;
    s1_nxt.p[2] = in_ball_pos_z;
    s1_nxt.v[0] = in_ball_vel_x;
    s1_nxt.v[1] = in_ball_vel_y;
    s1_nxt.v[2] = in_ball_vel_z;
    s1_nxt.r    = in_ball_radius;
    s1_nxt.dt   = in_time_step;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.d[i] = 33'($signed(s1_nxt.p[i])) - 33'($signed(cfg.plane[i]));
    end
  end

  always_comb begin
    s2_nxt.p  = s1_r.p;
    s2_nxt.v  = s1_r.v;
    s2_nxt.r  = s1_r.r;
    s2_nxt.dt = s1_r.dt;
    for (int i = 0; i < 3; i++) begin
      s2_nxt.pd[i] = $signed(s1_r.d[i]) * $signed(cfg.nrm[i]);
      s2_nxt.pv[i] = $signed(s1_r.v[i]) * $signed(cfg.nrm[i]);
    end
  end

  always_comb begin
    sd = 53'($signed(s2_r.pd[0])) + 53'($signed(s2_r.pd[1])) + 53'($signed(s2_r.pd[2]));
    sv = 52'($signed(s2_r.pv[0])) + 52'($signed(s2_r.pv[1])) + 52'($signed(s2_r.pv[2]));
    s3_nxt.p   = s2_r.p;
    s3_nxt.v   = s2_r.v;
    s3_nxt.dt  = s2_r.dt;
    s3_nxt.sep = SEPW'($signed(sd[52:FRAC])) - SEPW'(s2_r.r);
    s3_nxt.vn  = sv[51:FRAC];
  end

  always_comb begin
    negsep = 39'sd0 - 39'($signed(s3_r.sep));
    fb     = 19'(cfg.fric) + 19'(cfg.bnc);
    q_item.p     = s3_r.p;
    q_item.v     = s3_r.v;
    q_item.dt    = s3_r.dt;
    q_item.sep   = s3_r.sep;
    q_item.vn    = s3_r.vn;
    q_item.touch = s3_r.sep[SEPW-1] || (s3_r.sep == '0);
    q_item.appr  = s3_r.vn[VNW-1];
    q_item.kp    = $signed(s3_r.vn) * $signed({1'b0, fb});
    for (int i = 0; i < 3; i++) begin
      q_item.m[i]  = $signed(cfg.nrm[i]) * negsep;
      q_item.vf[i] = $signed(s3_r.v[i]) * $signed({1'b0, cfg.fric});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (fe) begin
      s1_v_r <= in_push;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

endmodule

>>> design/spc_fifo.sv
// Short word queue between the front and back pipelines.
// Depends on spc_pkg for the word type and depth.
module spc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  spc_pkg::item_t  wdata,
  output logic            full,
  input  logic            pop,
  output spc_pkg::item_t  rdata,
  output logic            empty
);
  import spc_pkg::*;

  item_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r, cnt_nxt;

  assign full  = (cnt_r == (QAW+1)'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QAW+1)'(QDEPTH)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full)) else $error("push into full queue");
  a_cnt_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 1'b1) else $error("queue count slip");

endmodule

>>> design/spc_back.sv
// Back pipeline: reflection, pipelined impact-time divider, contact move and
// output register. Depends on spc_pkg.
module spc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  spc_pkg::cfg_t      cfg,
  input  logic               q_empty,
  input  spc_pkg::item_t     q_item,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  output logic               out_swept_hit,
  output logic [30:0]        out_time_left
);
  import spc_pkg::*;

  typedef struct packed {
    logic [2:0][31:0]    p;
    logic [2:0][31:0]    v;
    logic [2:0][VFW-1:0] vf;
    logic [2:0][NKW-1:0] nk;
    logic [2:0][31:0]    pt;
    logic [30:0]         dt;
    logic                touch;
    logic                appr;
    logic                ovf;
    logic [REMW-1:0]     rem;
    logic [DVW-1:0]      dvs;
  } b1_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0][31:0] pt;
    logic [2:0][31:0] vr;
    logic [30:0]      dt;
    logic             touch;
    logic             appr;
    logic             ovf;
    logic [REMW-1:0]  rem;
    logic [DVW-1:0]   dvs;
    logic [QW-1:0]    q;
  } dv_t;

  typedef struct packed {
    logic [2:0][31:0]    p;
    logic [2:0][31:0]    v;
    logic [2:0][31:0]    pt;
    logic [2:0][31:0]    vr;
    logic [30:0]         dt;
    logic                touch;
    logic                appr;
    logic                ovf;
    logic [QW-1:0]       q;
    logic [2:0][VTW-1:0] vt;
  } mt_t;

  logic                adv;
  logic signed [KW-1:0] k;
  b1_t                 b1_r, b1_nxt;
  logic                b1_v_r;
  dv_t                 dv_in  [QW];
  dv_t                 dv_nxt [QW];
  dv_t                 dv_r   [QW];
  logic [TW-1:0]       trial  [QW];
  logic [QW-1:0]       dv_v_r;
  mt_t                 mt_r, mt_nxt;
  logic                mt_v_r;
  logic                out_v_r;
  logic                hit;
  logic [2:0][31:0]    ph;
  logic [2:0][31:0]    np_nxt, nv_nxt;
  logic [30:0]         tl_nxt;
  logic [2:0][31:0]    np_r, nv_r;
  logic                hit_r;
  logic [30:0]         tl_r;

  assign adv       = !out_v_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !out_v_r;

  always_comb begin
    k = q_item.kp[KPW-1:FRAC];
    b1_nxt.p     = q_item.p;
    b1_nxt.v     = q_item.v;
    b1_nxt.vf    = q_item.vf;
    b1_nxt.dt    = q_item.dt;
    b1_nxt.touch = q_item.touch;
    b1_nxt.appr  = q_item.appr;
    for (int i = 0; i < 3; i++) begin
      b1_nxt.nk[i] = $signed(cfg.nrm[i]) * k;
      b1_nxt.pt[i] = sat32(64'($signed(q_item.p[i])) + 64'($signed(q_item.m[i][MW-1:FRAC])));
    end
    b1_nxt.dvs = DVW'(0) - DVW'($signed(q_item.vn));
    b1_nxt.rem = {q_item.sep[SEPW-2:0], {FRAC{1'b0}}};
    b1_nxt.ovf = OVW'(q_item.sep[SEPW-2:0]) >= (OVW'(b1_nxt.dvs) << (QW - FRAC));
  end

  always_comb begin
    dv_in[0].p     = b1_r.p;
    dv_in[0].v     = b1_r.v;
    dv_in[0].pt    = b1_r.pt;
    dv_in[0].dt    = b1_r.dt;
    dv_in[0].touch = b1_r.touch;
    dv_in[0].appr  = b1_r.appr;
    dv_in[0].ovf   = b1_r.ovf;
    dv_in[0].rem   = b1_r.rem;
    dv_in[0].dvs   = b1_r.dvs;
    dv_in[0].q     = '0;
    for (int i = 0; i < 3; i++) begin
      dv_in[0].vr[i] = sat32(64'($signed(b1_r.vf[i][VFW-1:FRAC]))
                             - 64'($signed(b1_r.nk[i][NKW-1:FRAC])));
    end
    for (int j = 1; j < QW; j++) dv_in[j] = dv_r[j-1];
    for (int j = 0; j < QW; j++) begin
      dv_nxt[j] = dv_in[j];
      trial[j]  = TW'(dv_in[j].dvs) << (QW - 1 - j);
      if (TW'(dv_in[j].rem) >= trial[j]) begin
        dv_nxt[j].rem          = dv_in[j].rem - REMW'(trial[j]);
        dv_nxt[j].q[QW-1-j]    = 1'b1;
      end
    end
  end

  always_comb begin
    mt_nxt.p     = dv_r[QW-1].p;
    mt_nxt.v     = dv_r[QW-1].v;
    mt_nxt.pt    = dv_r[QW-1].pt;
    mt_nxt.vr    = dv_r[QW-1].vr;
    mt_nxt.dt    = dv_r[QW-1].dt;
    mt_nxt.touch = dv_r[QW-1].touch;
    mt_nxt.appr  = dv_r[QW-1].appr;
    mt_nxt.ovf   = dv_r[QW-1].ovf;
    mt_nxt.q     = dv_r[QW-1].q;
    for (int i = 0; i < 3; i++) begin
      mt_nxt.vt[i] = $signed(dv_r[QW-1].v[i]) * $signed({1'b0, dv_r[QW-1].q});
    end
  end

  always_comb begin
    hit = !mt_r.touch && mt_r.appr && !mt_r.ovf && (mt_r.q <= mt_r.dt);
    for (int i = 0; i < 3; i++) begin
      ph[i] = sat32(64'($signed(mt_r.p[i])) + 64'($signed(mt_r.vt[i][VTW-1:FRAC])));
      if (mt_r.touch) np_nxt[i] = mt_r.pt[i];
      else if (hit) np_nxt[i] = ph[i];
      else np_nxt[i] = mt_r.p[i];
      nv_nxt[i] = ((mt_r.touch && mt_r.appr) || hit) ? mt_r.vr[i] : mt_r.v[i];
    end
    tl_nxt = hit ? (mt_r.dt - mt_r.q) : mt_r.dt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      dv_v_r  <= '0;
      mt_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= !q_empty;
      dv_v_r  <= {dv_v_r[QW-2:0], b1_v_r};
      mt_v_r  <= dv_v_r[QW-1];
      out_v_r <= mt_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_r <= b1_nxt;
      for (int j = 0; j < QW; j++) dv_r[j] <= dv_nxt[j];
      mt_r  <= mt_nxt;
      np_r  <= np_nxt;
      nv_r  <= nv_nxt;
      hit_r <= hit;
      tl_r  <= tl_nxt;
    end
  end

  assign out_new_pos_x = $signed(np_r[0]);
  assign out_new_pos_y = $signed(np_r[1]);
  assign out_new_pos_z = $signed(np_r[2]);
  assign out_new_vel_x = $signed(nv_r[0]);
  assign out_new_vel_y = $signed(nv_r[1]);
  assign out_new_vel_z = $signed(nv_r[2]);
  assign out_swept_hit = hit_r;
  assign out_time_left = tl_r;

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(dv_v_r) && $stable(mt_v_r)) else $error("back moved while stalled");
  a_pop_adv: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> adv && !q_empty) else $error("queue read without advance");
  a_hit_only_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && mt_v_r && hit) |=> out_swept_hit && !out_empty) else $error("hit lost");

endmodule
